[hdl/ber_enc_pkg.sv]
// Shared types and codes for the BER integer/null TLV encoder.
package ber_enc_pkg;

  localparam logic [1:0] OP_SIGNED   = 2'd0;
  localparam logic [1:0] OP_UNSIGNED = 2'd1;
  localparam logic [1:0] OP_NULL     = 2'd2;
  localparam logic [1:0] OP_RSVD     = 2'd3;

  localparam logic [7:0] NULL_TAG_RESET = 8'h05;
  localparam logic [7:0] OCTET_ZERO     = 8'h00;
  localparam logic [7:0] OCTET_ONES     = 8'hFF;

  // content candidates: nine octets, most significant first
  localparam int CONT_OCTETS = 9;
  localparam int CONT_W      = CONT_OCTETS * 8;
  // tag + length + content
  localparam int FRAME_W     = CONT_W + 16;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] value;
    logic [7:0]  tag_octet;
  } ber_in_t;

  typedef struct packed {
    logic [7:0] out_octet;
    logic       last;
  } ber_out_t;

endpackage

[hdl/ber_integer_tlv_encoder.sv]
// Top level: BER TLV encoder for signed, unsigned and null values.
//
// Each transaction (start high while busy is low) yields 2 to 11 octets on
// out_item, one per cycle, each marked by out_valid for one cycle, the final one
// with last set: null gives 2, signed 32-bit 3..6, unsigned 64-bit 3..11.
// The output serializer sends one octet a cycle, so an item occupies it until
// its last octet has gone out; an accepted item passes through stages A, B
// and C before the serializer loads it. A new item is taken while the previous
// one is still being sent, so encodings follow each other without gaps.
// The receiver cannot stall the output.
// Operation code 3 is accepted and produces nothing. A write on cfg_we and
// cfg_wdata sets the identifier octet sent for null values (reset 5).
module ber_integer_tlv_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ber_enc_pkg::ber_in_t  in_item,
  output logic                  out_valid,
  output ber_enc_pkg::ber_out_t out_item,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);
  import ber_enc_pkg::*;

  logic accept;

  // config
  logic [7:0] null_tag_r, null_tag_nxt;

  // stage A: captured input
  logic       va_r, va_nxt;
  ber_in_t    a_item_r, a_item_nxt;

  // stage B: content candidates and per-octet removable flags
  logic              vb_r, vb_nxt;
  logic [CONT_W-1:0] b_cont_r, b_cont_nxt;
  logic [7:0]        b_rm_r, b_rm_nxt;
  logic              b_null_r, b_null_nxt;
  logic [7:0]        b_tag_r, b_tag_nxt;

  // stage C: framed octets and count
  logic               vc_r, vc_nxt;
  logic [FRAME_W-1:0] c_frame_r, c_frame_nxt;
  logic [3:0]         c_cnt_r, c_cnt_nxt;

  // stage D: serializer
  logic [FRAME_W-1:0] sh_r, sh_nxt;
  logic [3:0]         rem_r, rem_nxt;

  logic d_load, c_take, b_take;

  // stage B combinational
  logic              neg;
  logic [7:0]        pad;
  logic [CONT_W-1:0] cont;
  logic [7:0]        rm;

  // stage C combinational
  logic [3:0]        first;
  logic              run;
  logic [3:0]        clen;
  logic [CONT_W-1:0] shifted;
  logic [7:0]        tag_sel;

  assign d_load = (rem_r <= 4'd1);
  assign c_take = !vc_r || d_load;
  assign b_take = !vb_r || c_take;
  assign busy   = va_r && !b_take;
  assign accept = start && !busy;

  always_comb begin
    null_tag_nxt = cfg_we ? cfg_wdata : null_tag_r;
  end

  // stage A
  always_comb begin
    va_nxt     = va_r;
    a_item_nxt = a_item_r;
    if (!busy) begin
      va_nxt     = accept && (in_item.operation != OP_RSVD);
      a_item_nxt = in_item;
    end
  end

  // stage B: one nine-octet view for both integer modes; signed mode gets
  // five sign octets in front, which the removal rule always strips
  always_comb begin
    neg = (a_item_r.operation == OP_SIGNED) && a_item_r.value[31];
    pad = neg ? OCTET_ONES : OCTET_ZERO;
    if (a_item_r.operation == OP_SIGNED) begin
      cont = {{5{pad}}, a_item_r.value[31:0]};
    end else begin
      cont = {OCTET_ZERO, a_item_r.value};
    end
    for (int i = 0; i < CONT_OCTETS - 1; i++) begin
      rm[i] = (cont[CONT_W-1-8*i -: 8] == pad) && (cont[CONT_W-1-8*(i+1)] == neg);
    end
  end

  always_comb begin
    vb_nxt     = vb_r;
    b_cont_nxt = b_cont_r;
    b_rm_nxt   = b_rm_r;
    b_null_nxt = b_null_r;
    b_tag_nxt  = b_tag_r;
    if (b_take) begin
      vb_nxt     = va_r;
      b_cont_nxt = cont;
      b_rm_nxt   = rm;
      b_null_nxt = (a_item_r.operation == OP_NULL);
      b_tag_nxt  = a_item_r.tag_octet;
    end
  end

  // stage C: count leading removable octets, left-justify content
  always_comb begin
    first = 4'd0;
    run   = 1'b1;
    for (int i = 0; i < CONT_OCTETS - 1; i++) begin
      run = run && b_rm_r[i];
      if (run) first = first + 4'd1;
    end
    clen    = b_null_r ? 4'd0 : 4'(CONT_OCTETS) - first;
    shifted = b_cont_r << {first, 3'b000};
    tag_sel = b_null_r ? null_tag_r : b_tag_r;
  end

  always_comb begin
    vc_nxt      = vc_r;
    c_frame_nxt = c_frame_r;
    c_cnt_nxt   = c_cnt_r;
    if (c_take) begin
      vc_nxt      = vb_r;
      c_frame_nxt = {tag_sel, 4'd0, clen, shifted};
      c_cnt_nxt   = clen + 4'd2;
    end
  end

  // stage D
  always_comb begin
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    if (d_load) begin
      sh_nxt  = c_frame_r;
      rem_nxt = vc_r ? c_cnt_r : 4'd0;
    end else begin
      sh_nxt  = sh_r << 8;
      rem_nxt = rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_tag_r <= NULL_TAG_RESET;
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      rem_r      <= 4'd0;
    end else begin
      null_tag_r <= null_tag_nxt;
      va_r       <= va_nxt;
      vb_r       <= vb_nxt;
      vc_r       <= vc_nxt;
      rem_r      <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r  <= a_item_nxt;
    b_cont_r  <= b_cont_nxt;
    b_rm_r    <= b_rm_nxt;
    b_null_r  <= b_null_nxt;
    b_tag_r   <= b_tag_nxt;
    c_frame_r <= c_frame_nxt;
    c_cnt_r   <= c_cnt_nxt;
    sh_r      <= sh_nxt;
  end

  assign out_valid          = (rem_r != 4'd0);
  assign out_item.out_octet = sh_r[FRAME_W-1 -: 8];
  assign out_item.last      = (rem_r == 4'd1);

  // an encoding is never broken off mid-way
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("output gap inside an encoding");

  // serializer never holds more than the longest encoding
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 4'd11)
    else $error("serializer count out of range");

  // busy is raised only while stages A, B and C are all full and the serializer is not loading
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> va_r && vb_r && vc_r && !d_load)
    else $error("busy without a full pipeline");

endmodule
